### rtl/basic_statement_executor_unit_defines.svh
// Assertion macros shared by the statement executor RTL.
// Each file that asserts includes this header; it needs clk and rst_n in scope.
`ifndef BASIC_STATEMENT_EXECUTOR_UNIT_DEFINES_SVH
`define BASIC_STATEMENT_EXECUTOR_UNIT_DEFINES_SVH

// Check a property on every clock edge outside of reset
`define BSE_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included
`define BSE_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### rtl/bse_pkg.sv
// Shared types and constants of the tiny BASIC statement executor.
// Used by bse_alu and basic_statement_executor_unit; no dependencies.
`default_nettype none

package bse_pkg;

    // Data path and program sizes
    localparam int DATA_W        = 32;
    localparam int COUNT_W       = $clog2(DATA_W);
    localparam int VAR_COUNT     = 26;
    localparam int VAR_IDX_W     = 5;
    localparam int LINE_W        = 11;
    localparam int JUMP_W        = 10;
    localparam int PROGRAM_DEPTH = 1024;
    localparam int OP_W          = 3;
    localparam int MODE_W        = 2;

    // Input tdata layout, lowest field first
    localparam int IN_DEST_LSB  = 0;
    localparam int IN_AVAR_BIT  = IN_DEST_LSB + VAR_IDX_W;
    localparam int IN_AVAL_LSB  = IN_AVAR_BIT + 1;
    localparam int IN_BVAR_BIT  = IN_AVAL_LSB + DATA_W;
    localparam int IN_BVAL_LSB  = IN_BVAR_BIT + 1;
    localparam int IN_OP_LSB    = IN_BVAL_LSB + DATA_W;
    localparam int IN_JUMP_LSB  = IN_OP_LSB + OP_W;
    localparam int IN_NL_BIT    = IN_JUMP_LSB + JUMP_W;
    localparam int IN_USED_W    = IN_NL_BIT + 1;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;
    localparam int IN_TUSER_W   = MODE_W;

    // Output tdata layout, lowest field first
    localparam int OUT_USED_W   = LINE_W + 1 + DATA_W + 1 + 1;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    // Statement kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_ASSIGN     = 2'd0,
        MODE_JUMP       = 2'd1,
        MODE_PRINT_VAR  = 2'd2,
        MODE_PRINT_TEXT = 2'd3
    } mode_t;

    // Assignment operations
    localparam logic [OP_W-1:0] OP_COPY = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

    // Jump relations
    localparam logic [OP_W-1:0] REL_EQ = 3'd0;
    localparam logic [OP_W-1:0] REL_GT = 3'd1;
    localparam logic [OP_W-1:0] REL_LT = 3'd2;
    localparam logic [OP_W-1:0] REL_NE = 3'd3;
    localparam logic [OP_W-1:0] REL_LE = 3'd4;
    localparam logic [OP_W-1:0] REL_GE = 3'd5;

    // Shared arithmetic unit commands
    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_SUB = 3'd1,
        ALU_CMP = 3'd2,
        ALU_MUL = 3'd3,
        ALU_DIV = 3'd4
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
        logic              lt;
        logic              eq;
    } alu_rsp_t;

    // Saturate a line index at the end of the program
    function automatic logic [LINE_W-1:0] clamp_line(input logic [LINE_W-1:0] line);
        logic [LINE_W-1:0] limit;
        limit = LINE_W'(PROGRAM_DEPTH);
        return (line > limit) ? limit : line;
    endfunction

endpackage

`default_nettype wire

### rtl/bse_alu.sv
// Shared arithmetic unit: one 33-bit adder serves add, subtract, compare,
// shift-add multiply and restoring divide. Depends on bse_pkg.
`default_nettype none
`include "basic_statement_executor_unit_defines.svh"

module bse_alu (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bse_pkg::alu_req_t              req,
    input  logic [bse_pkg::DATA_W-1:0]     a,
    input  logic [bse_pkg::DATA_W-1:0]     b,
    output bse_pkg::alu_rsp_t              rsp
);
    import bse_pkg::*;

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_MUL  = 5'b00010,
        A_DIV  = 5'b00100,
        A_FIN  = 5'b01000,
        A_DONE = 5'b10000
    } alu_state_t;

    alu_state_t          state_reg, state_next;
    logic [DATA_W-1:0]   acc_reg;     // product accumulator or partial remainder
    logic [DATA_W-1:0]   opd_reg;     // multiplicand or divisor magnitude
    logic [DATA_W-1:0]   shf_reg;     // multiplier bits or dividend/quotient
    logic [COUNT_W-1:0]  count_reg;
    logic                neg_reg;
    logic                is_div_reg;
    logic [DATA_W-1:0]   result_reg;
    logic                lt_reg;
    logic                eq_reg;

    logic [DATA_W:0]     add_x;
    logic [DATA_W:0]     add_y;
    logic                add_sub;
    logic [DATA_W+1:0]   add_sum;
    logic                div_geq;
    logic [DATA_W-1:0]   a_mag;
    logic [DATA_W-1:0]   b_mag;
    logic                last_step;

    // Route operands to the shared adder
    always_comb
    begin
        add_x   = {a[DATA_W-1], a};
        add_y   = {b[DATA_W-1], b};
        add_sub = (req.op != ALU_ADD);
        unique case (state_reg)
            A_MUL:
            begin
                add_x   = {1'b0, acc_reg};
                add_y   = {1'b0, opd_reg};
                add_sub = 1'b0;
            end
            A_DIV:
            begin
                add_x   = {acc_reg, shf_reg[DATA_W-1]};
                add_y   = {1'b0, opd_reg};
                add_sub = 1'b1;
            end
            default:
            begin
            end
        endcase
        add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                + {{(DATA_W+1){1'b0}}, add_sub};
    end

    // Carry out of the trial subtract means the divisor fits
    assign div_geq   = add_sum[DATA_W+1];
    assign a_mag     = a[DATA_W-1] ? (~a + {{(DATA_W-1){1'b0}}, 1'b1}) : a;
    assign b_mag     = b[DATA_W-1] ? (~b + {{(DATA_W-1){1'b0}}, 1'b1}) : b;
    assign last_step = (count_reg == {COUNT_W{1'b1}});

    // Sequence the iterations
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    unique case (req.op)
                        ALU_MUL: state_next = A_MUL;
                        ALU_DIV: state_next = A_DIV;
                        default: state_next = A_DONE;
                    endcase
                end
            end
            A_MUL:   state_next = last_step ? A_FIN : A_MUL;
            A_DIV:   state_next = last_step ? A_FIN : A_DIV;
            A_FIN:   state_next = A_DONE;
            A_DONE:  state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            A_IDLE:
            begin
                count_reg <= '0;
                acc_reg   <= '0;
                if (req.start)
                begin
                    unique case (req.op)
                        ALU_MUL:
                        begin
                            opd_reg    <= a;
                            shf_reg    <= b;
                            is_div_reg <= 1'b0;
                        end
                        ALU_DIV:
                        begin
                            opd_reg    <= b_mag;
                            shf_reg    <= a_mag;
                            neg_reg    <= a[DATA_W-1] ^ b[DATA_W-1];
                            is_div_reg <= 1'b1;
                        end
                        default:
                        begin
                            result_reg <= add_sum[DATA_W-1:0];
                            lt_reg     <= add_sum[DATA_W];
                            eq_reg     <= (add_sum[DATA_W:0] == '0);
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                if (shf_reg[0])
                begin
                    acc_reg <= add_sum[DATA_W-1:0];
                end
                opd_reg   <= {opd_reg[DATA_W-2:0], 1'b0};
                shf_reg   <= {1'b0, shf_reg[DATA_W-1:1]};
                count_reg <= count_reg + 1'b1;
            end
            A_DIV:
            begin
                acc_reg   <= div_geq ? add_sum[DATA_W-1:0] : add_x[DATA_W-1:0];
                shf_reg   <= {shf_reg[DATA_W-2:0], div_geq};
                count_reg <= count_reg + 1'b1;
            end
            A_FIN:
            begin
                if (is_div_reg)
                begin
                    result_reg <= neg_reg ? (~shf_reg + {{(DATA_W-1){1'b0}}, 1'b1})
                                          : shf_reg;
                end
                else
                begin
                    result_reg <= acc_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done   = (state_reg == A_DONE);
    assign rsp.result = result_reg;
    assign rsp.lt     = lt_reg;
    assign rsp.eq     = eq_reg;

    `BSE_ASSERT(a_alu_start_idle, req.start |-> state_reg == A_IDLE, "start while busy")
    `BSE_ASSERT(a_alu_div_nonzero, state_reg == A_DIV |-> opd_reg != '0, "divide by zero")
    `BSE_ASSERT(a_alu_done_pulse, rsp.done |=> !rsp.done, "done held past one cycle")

endmodule

`default_nettype wire

### rtl/basic_statement_executor_unit.sv
// Top level of the tiny BASIC statement executor: stream ports, variable store,
// sequencer. Depends on bse_pkg, bse_alu and the assertion macro header.
`default_nettype none
`include "basic_statement_executor_unit_defines.svh"

// Executes one decoded statement per input transfer and returns one result
// transfer. An item runs through operand reads from the 26-entry variable
// store (one read per cycle), then the shared arithmetic unit where it is
// needed. Copy, print, unsupported operations and a division by zero skip
// the unit; add, subtract and compare use the adder once; multiply and
// divide run the 32 single-bit steps of the shared adder. Input is taken
// again the cycle after the result enters the output register, so the next
// item can start while the previous result still waits for the sink. The
// variable store clears at once on reset through per-entry valid bits; no
// clearing pass is needed. The line counter starts at zero and saturates at
// the program depth.
module basic_statement_executor_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // dest_var, first_is_var, first_value, second_is_var, second_value,
    // operation, jump_index, newline, zero fill
    input  logic [bse_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // mode
    input  logic [bse_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // next_line, print_valid, print_value, print_newline, divide_fault, zero fill
    output logic [bse_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import bse_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RDA  = 6'b000010,
        S_RDB  = 6'b000100,
        S_EXEC = 6'b001000,
        S_WAIT = 6'b010000,
        S_DONE = 6'b100000
    } exec_state_t;

    exec_state_t            state_reg, state_next;

    // Captured statement
    mode_t                  mode_reg;
    logic [VAR_IDX_W-1:0]   dest_reg;
    logic                   a_is_var_reg;
    logic [DATA_W-1:0]      a_val_reg;
    logic                   b_is_var_reg;
    logic [DATA_W-1:0]      b_val_reg;
    logic [OP_W-1:0]        oper_reg;
    logic [JUMP_W-1:0]      jump_reg;
    logic                   nl_reg;

    // Variable store
    logic [DATA_W-1:0]      var_mem [VAR_COUNT];
    logic [VAR_COUNT-1:0]   var_valid_reg;
    logic [DATA_W-1:0]      rd_idx;
    logic                   rd_in_range;
    logic [VAR_IDX_W-1:0]   rd_addr;
    logic [DATA_W-1:0]      rd_data_reg;
    logic                   rd_hit_reg;
    logic [DATA_W-1:0]      rd_value;

    // Operands and results
    logic [DATA_W-1:0]      a_opnd_reg;
    logic [DATA_W-1:0]      b_opnd;
    logic                   dest_ok;
    logic                   wr_pend_reg;
    logic [DATA_W-1:0]      wr_val_reg;
    logic                   taken_reg;
    logic                   pvalid_reg;
    logic [DATA_W-1:0]      pvalue_reg;
    logic                   fault_reg;
    logic [LINE_W-1:0]      cur_line_reg;
    logic [LINE_W-1:0]      next_line;
    logic                   print_nl;
    logic                   rel_true;

    // Output register
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    // Arithmetic unit handshake
    alu_req_t               alu_req;
    alu_rsp_t               alu_rsp;

    logic                   in_fire;
    logic                   done_fire;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign done_fire     = (state_reg == S_DONE) && (!m_valid_reg || m_axis_tready);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign dest_ok       = ({{(DATA_W-VAR_IDX_W){1'b0}}, dest_reg} < DATA_W'(VAR_COUNT));

    // Pick the store address: first operand (or print target), then second
    always_comb
    begin
        rd_idx = b_val_reg;
        if (state_reg == S_RDA)
        begin
            rd_idx = (mode_reg == MODE_PRINT_VAR)
                   ? {{(DATA_W-VAR_IDX_W){1'b0}}, dest_reg} : a_val_reg;
        end
        rd_in_range = (rd_idx < DATA_W'(VAR_COUNT));
        rd_addr     = rd_in_range ? rd_idx[VAR_IDX_W-1:0] : '0;
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (done_fire && wr_pend_reg)
        begin
            var_mem[dest_reg] <= wr_val_reg;
        end
        rd_data_reg <= var_mem[rd_addr];
        rd_hit_reg  <= rd_in_range && var_valid_reg[rd_addr];
    end

    // Entries never written read as zero
    assign rd_value = rd_hit_reg ? rd_data_reg : '0;
    assign b_opnd   = b_is_var_reg ? rd_value : b_val_reg;

    // Build the arithmetic unit request
    always_comb
    begin
        alu_req.start = 1'b0;
        alu_req.op    = ALU_CMP;
        if (state_reg == S_EXEC)
        begin
            unique case (mode_reg)
                MODE_ASSIGN:
                begin
                    unique case (oper_reg)
                        OP_ADD:
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_ADD;
                        end
                        OP_SUB:
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_SUB;
                        end
                        OP_MUL:
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_MUL;
                        end
                        OP_DIV:
                        begin
                            alu_req.start = (b_opnd != '0);
                            alu_req.op    = ALU_DIV;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                MODE_JUMP:
                begin
                    alu_req.start = (oper_reg <= REL_GE);
                    alu_req.op    = ALU_CMP;
                end
                default:
                begin
                end
            endcase
        end
    end

    bse_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (a_opnd_reg),
        .b      (b_opnd),
        .rsp    (alu_rsp)
    );

    // Evaluate the jump relation from the compare flags
    always_comb
    begin
        unique case (oper_reg)
            REL_EQ:  rel_true = alu_rsp.eq;
            REL_GT:  rel_true = !alu_rsp.lt && !alu_rsp.eq;
            REL_LT:  rel_true = alu_rsp.lt;
            REL_NE:  rel_true = !alu_rsp.eq;
            REL_LE:  rel_true = alu_rsp.lt || alu_rsp.eq;
            REL_GE:  rel_true = !alu_rsp.lt;
            default: rel_true = 1'b0;
        endcase
    end

    // Next line: jump target or advance, both saturated
    assign next_line = taken_reg ? clamp_line({1'b0, jump_reg})
                                 : clamp_line(cur_line_reg + 1'b1);
    assign print_nl  = ((mode_reg == MODE_PRINT_VAR) || (mode_reg == MODE_PRINT_TEXT))
                     && nl_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = in_fire ? S_RDA : S_IDLE;
            S_RDA:   state_next = S_RDB;
            S_RDB:   state_next = S_EXEC;
            S_EXEC:  state_next = alu_req.start ? S_WAIT : S_DONE;
            S_WAIT:  state_next = alu_rsp.done ? S_DONE : S_WAIT;
            S_DONE:  state_next = done_fire ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            cur_line_reg  <= '0;
            var_valid_reg <= '0;
            wr_pend_reg   <= 1'b0;
            taken_reg     <= 1'b0;
            pvalid_reg    <= 1'b0;
            fault_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Settle outcome of statements that skip the arithmetic unit
            if (state_reg == S_EXEC)
            begin
                wr_pend_reg <= (mode_reg == MODE_ASSIGN) && (oper_reg == OP_COPY) && dest_ok;
                taken_reg   <= 1'b0;
                pvalid_reg  <= (mode_reg == MODE_PRINT_VAR);
                fault_reg   <= (mode_reg == MODE_ASSIGN) && (oper_reg == OP_DIV)
                             && (b_opnd == '0);
            end

            // Take the arithmetic result
            if ((state_reg == S_WAIT) && alu_rsp.done)
            begin
                wr_pend_reg <= (mode_reg == MODE_ASSIGN) && dest_ok;
                taken_reg   <= (mode_reg == MODE_JUMP) && rel_true;
            end

            // Retire: commit the write, advance the line, fill the output register
            if (done_fire)
            begin
                m_valid_reg  <= 1'b1;
                cur_line_reg <= next_line;
                wr_pend_reg  <= 1'b0;
                if (wr_pend_reg)
                begin
                    var_valid_reg[dest_reg] <= 1'b1;
                end
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg     <= mode_t'(s_axis_tuser[MODE_W-1:0]);
            dest_reg     <= s_axis_tdata[IN_DEST_LSB +: VAR_IDX_W];
            a_is_var_reg <= s_axis_tdata[IN_AVAR_BIT];
            a_val_reg    <= s_axis_tdata[IN_AVAL_LSB +: DATA_W];
            b_is_var_reg <= s_axis_tdata[IN_BVAR_BIT];
            b_val_reg    <= s_axis_tdata[IN_BVAL_LSB +: DATA_W];
            oper_reg     <= s_axis_tdata[IN_OP_LSB +: OP_W];
            jump_reg     <= s_axis_tdata[IN_JUMP_LSB +: JUMP_W];
            nl_reg       <= s_axis_tdata[IN_NL_BIT];
        end
        if (state_reg == S_RDB)
        begin
            a_opnd_reg <= ((mode_reg == MODE_PRINT_VAR) || a_is_var_reg)
                        ? rd_value : a_val_reg;
        end
        if (state_reg == S_EXEC)
        begin
            wr_val_reg <= a_opnd_reg;
            pvalue_reg <= (mode_reg == MODE_PRINT_VAR) ? a_opnd_reg : '0;
        end
        if ((state_reg == S_WAIT) && alu_rsp.done)
        begin
            wr_val_reg <= alu_rsp.result;
        end
        if (done_fire)
        begin
            m_data_reg <= {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, fault_reg, print_nl,
                           pvalue_reg, pvalid_reg, next_line};
        end
    end

    `BSE_ASSERT(a_alu_done_in_wait, alu_rsp.done |-> state_reg == S_WAIT, "stray unit result")
    `BSE_ASSERT_ALWAYS(a_line_bound, !rst_n || (cur_line_reg <= LINE_W'(PROGRAM_DEPTH)), "line past end")
    `BSE_ASSERT(a_write_legal, (done_fire && wr_pend_reg) |-> (dest_ok && !fault_reg),
        "illegal variable write")

endmodule

`default_nettype wire
